>>> hdl/sfcs_pkg.sv
// ============================================================================
// SPI flash command slave package
// Command codes, reply constants and the structures that pass between the
// command decoder, the flash array and the output register.
// ============================================================================
package sfcs_pkg;

    localparam int unsigned FLASH_BYTES_DEF = 262144;
    localparam int unsigned ADDR_W          = 24;

    localparam logic [7:0] CMD_WRDI = 8'h04;
    localparam logic [7:0] CMD_RDSR = 8'h05;
    localparam logic [7:0] CMD_WREN = 8'h06;
    localparam logic [7:0] CMD_READ = 8'h03;
    localparam logic [7:0] CMD_PW   = 8'h0A;
    localparam logic [7:0] CMD_RDID = 8'h9F;

    localparam logic [7:0] ID_BYTE_1  = 8'h20;
    localparam logic [7:0] ID_BYTE_2  = 8'h40;
    localparam logic [7:0] ID_BYTE_3  = 8'h12;
    localparam logic [7:0] STATUS_WEL = 8'h02;

    localparam logic [2:0] POS_CMD   = 3'd1;
    localparam logic [2:0] POS_ID_2  = 3'd2;
    localparam logic [2:0] POS_ID_3  = 3'd3;
    localparam logic [2:0] POS_DATA  = 3'd4;

    typedef struct packed {
        logic              wr;
        logic              rd;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } t_mem_req;

    typedef struct packed {
        logic       mem_rd;
        logic [7:0] data;
    } t_ctrl_res;

endpackage

>>> hdl/sfcs_ctrl.sv
// ============================================================================
// SPI flash command decoder
// Holds the command state and works out the reply byte and the flash access
// for each accepted request.
// ============================================================================
module sfcs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_data_in,
    input  logic               i_keep_selected,
    output sfcs_pkg::t_mem_req  o_mem_req,
    output sfcs_pkg::t_ctrl_res o_res
);
    import sfcs_pkg::*;

    logic              r_selected, n_selected;
    logic [7:0]        r_command,  n_command;
    logic [2:0]        r_pos,      n_pos;
    logic [ADDR_W-1:0] r_address,  n_address;
    logic              r_wel,      n_wel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_selected <= 1'b0;
            r_command  <= '0;
            r_pos      <= '0;
            r_address  <= '0;
            r_wel      <= 1'b0;
        end else begin
            r_selected <= n_selected;
            r_command  <= n_command;
            r_pos      <= n_pos;
            r_address  <= n_address;
            r_wel      <= n_wel;
        end
    end

    always_comb begin
        n_selected = r_selected;
        n_command  = r_command;
        n_pos      = r_pos;
        n_address  = r_address;
        n_wel      = r_wel;
        o_mem_req  = '0;
        o_res      = '0;
        if (i_accept) begin
            if (!r_selected) begin
                n_selected = 1'b1;
                n_command  = i_data_in;
                n_pos      = POS_CMD;
                n_address  = '0;
                if (i_data_in == CMD_WRDI) begin
                    n_wel = 1'b0;
                end else if (i_data_in == CMD_WREN) begin
                    n_wel = 1'b1;
                end
            end else begin
                case (r_command)
                    CMD_RDSR: begin
                        o_res.data = r_wel ? STATUS_WEL : 8'h00;
                    end
                    CMD_RDID: begin
                        case (r_pos)
                            POS_CMD:  o_res.data = ID_BYTE_1;
                            POS_ID_2: o_res.data = ID_BYTE_2;
                            POS_ID_3: o_res.data = ID_BYTE_3;
                            default:  o_res.data = 8'h00;
                        endcase
                    end
                    CMD_READ, CMD_PW: begin
                        if (r_pos < POS_DATA) begin
                            n_address = {r_address[ADDR_W-9:0], i_data_in};
                        end else begin
                            o_mem_req.addr = r_address;
                            if (r_command == CMD_READ) begin
                                o_mem_req.rd = 1'b1;
                                o_res.mem_rd = 1'b1;
                            end else begin
                                o_mem_req.wr    = 1'b1;
                                o_mem_req.wdata = i_data_in;
                                o_res.data      = i_data_in;
                            end
                            n_address = r_address + {{(ADDR_W-1){1'b0}}, 1'b1};
                        end
                    end
                    default: begin
                        o_res.data = 8'h00;
                    end
                endcase
                if (r_pos < POS_DATA) begin
                    n_pos = r_pos + 3'd1;
                end
            end
            if (!i_keep_selected) begin
                n_selected = 1'b0;
                n_command  = '0;
            end
        end
    end

    a_no_rd_and_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_mem_req.wr && o_mem_req.rd))
        else $error("Flash read and write requested together.");

    a_wr_only_in_pw_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_req.wr |-> (r_selected && r_command == CMD_PW && r_pos == POS_DATA))
        else $error("Flash write outside the data phase of a write command.");

    a_pos_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_DATA)
        else $error("Byte position ran past saturation.");

    a_deselect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_keep_selected) |=> (!r_selected && r_command == 8'h00))
        else $error("Block stayed selected after a final byte.");

    a_idle_no_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_selected |-> r_command == 8'h00)
        else $error("Command held while deselected.");

endmodule

>>> hdl/sfcs_mem.sv
// ============================================================================
// SPI flash array
// Byte-wide single-port flash storage with registered read data. The read
// register holds its value until the next read.
// ============================================================================
module sfcs_mem #(
    parameter int unsigned FLASH_BYTES = sfcs_pkg::FLASH_BYTES_DEF
) (
    input  logic               i_clk,
    input  sfcs_pkg::t_mem_req i_mem_req,
    output logic [7:0]         o_rdata
);
    import sfcs_pkg::*;

    localparam int unsigned AW = $clog2(FLASH_BYTES);

    logic [7:0]    r_mem [FLASH_BYTES];
    logic [7:0]    r_rdata;
    logic [AW-1:0] idx;

    assign idx     = i_mem_req.addr[AW-1:0];
    assign o_rdata = r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_mem_req.wr) begin
            r_mem[idx] <= i_mem_req.wdata;
        end
        if (i_mem_req.rd) begin
            r_rdata <= r_mem[idx];
        end
    end

endmodule

>>> hdl/spi_flash_command_slave.sv
// ============================================================================
// SPI flash command slave
// Byte-level slave side of an SPI serial flash with status, ID, read and
// write commands.
// ============================================================================
// Each input request carries one byte from the master and a keep-selected
// flag; each request produces exactly one output byte. The first byte after
// a deselect is the command. Commands 03 and 0A take a three-byte address
// and then read or write one flash byte per request with a wrapping,
// incrementing address. FLASH_BYTES must be a power of two.
// A reply is valid in the cycle after its request is
// accepted. A new request is accepted every cycle, also while the previous
// reply is being taken, because the reply sits in an output register and
// flash reads use the registered read port of the array.
// When the receiver stalls, the reply is held and no new request is taken
// until it has been accepted. Synchronous reset deselects the block, clears
// the command state and the write-enable latch and empties the output
// register. The flash array is not cleared; a byte reads as written data
// only after it has been written.
// ============================================================================
module spi_flash_command_slave #(
    parameter int unsigned FLASH_BYTES = sfcs_pkg::FLASH_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_in,
    input  logic       i_keep_selected,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_data_out
);
    import sfcs_pkg::*;

    logic       accept;
    t_mem_req   mem_req;
    t_ctrl_res  res;
    logic [7:0] mem_rdata;
    logic       r_out_valid;
    logic       r_sel_mem;
    logic [7:0] r_data;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    sfcs_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_data_in       (i_data_in),
        .i_keep_selected (i_keep_selected),
        .o_mem_req       (mem_req),
        .o_res           (res)
    );

    sfcs_mem #(
        .FLASH_BYTES (FLASH_BYTES)
    ) u_mem (
        .i_clk     (i_clk),
        .i_mem_req (mem_req),
        .o_rdata   (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sel_mem <= res.mem_rd;
            r_data    <= res.data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_sel_mem ? mem_rdata : r_data;

endmodule
